### sv/stoi_pkg.sv
// Shared types, character constants and helpers for the string-to-integer parser.
// No dependencies; imported by stoi_alphabet and string_to_integer_any_base.
package stoi_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned ALPHA_W    = 64;
    localparam int unsigned BLEN_W     = 5;
    localparam int unsigned DIGIT_IDX_W = 4;   // enough for 16 symbols
    localparam int unsigned CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN = 2'd2;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [BLEN_W-1:0] MIN_RADIX = 5'd2;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last_char;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      base_valid;
    } t_out_word;

    // digit lookup result for one character
    typedef struct packed {
        logic                   hit;
        logic [DIGIT_IDX_W-1:0] idx;
    } t_digit;

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF)  || (c == CH_CR) || (c == CH_SPACE);
    endfunction

    function automatic logic is_sign(input logic [CH_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

### sv/stoi_alphabet.sv
// Alphabet unit: digit lookup by parallel compare, radix saturation, alphabet check.
// Depends on stoi_pkg.
module stoi_alphabet import stoi_pkg::*; #(
    parameter int MAX_DIGITS = 16
) (
    input  logic [CH_W-1:0]    i_ch,
    input  logic [ALPHA_W-1:0] i_alpha_lo,
    input  logic [ALPHA_W-1:0] i_alpha_hi,
    input  logic [BLEN_W-1:0]  i_base_len,
    output t_digit             o_digit,
    output logic [BLEN_W-1:0]  o_radix,
    output logic               o_base_valid
);

    localparam logic [BLEN_W-1:0] RADIX_MAX = BLEN_W'(MAX_DIGITS);

    logic [CH_W-1:0] w_sym [16];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_sym[i]     = i_alpha_lo[8*i +: 8];
            w_sym[i + 8] = i_alpha_hi[8*i +: 8];
        end
    end

    assign o_radix = (i_base_len > RADIX_MAX) ? RADIX_MAX : i_base_len;

    // lowest matching position wins
    always_comb begin
        o_digit = '0;
        for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
            if ((BLEN_W'(i) < o_radix) && (w_sym[i] == i_ch)) begin
                o_digit.hit = 1'b1;
                o_digit.idx = DIGIT_IDX_W'(i);
            end
        end
        if (i_ch == CH_NUL) begin
            o_digit.hit = 1'b0;
        end
    end

    // length range, pairwise duplicate and forbidden-symbol check
    always_comb begin
        o_base_valid = (i_base_len >= MIN_RADIX) && (i_base_len <= RADIX_MAX);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (BLEN_W'(i) < i_base_len) begin
                if ((w_sym[i] == CH_NUL) || is_sign(w_sym[i]) || is_space(w_sym[i])) begin
                    o_base_valid = 1'b0;
                end
                for (int j = i + 1; j < MAX_DIGITS; j++) begin
                    if ((BLEN_W'(j) < i_base_len) && (w_sym[j] == w_sym[i])) begin
                        o_base_valid = 1'b0;
                    end
                end
            end
        end
    end

endmodule

### sv/string_to_integer_any_base.sv
// Top level: streaming string-to-integer parser with a configurable digit alphabet.
// Depends on stoi_pkg and stoi_alphabet.
//
// Usage:
//   Input channel (i_in_valid / i_in_word / o_in_stall) takes one character
//   word per cycle while o_in_stall is low; last_char marks the end of a
//   string. Only a word with last_char set produces a result word on the
//   output channel (o_out_valid / o_out_word / i_out_stall): the signed
//   value, wrapped to 32 bits, and the alphabet check flag.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; index 0 and 1
//   load the low and high alphabet words, index 2 the base length. Write it
//   only while no string is in flight.
//   A character is registered at acceptance and parsed from the input register;
//   a last character's result is registered in the output register. Throughput
//   is one word per cycle while o_in_stall is low, set by the single multiply-add
//   (accumulator times radix plus digit) in the parse stage.
//   Receiver stall: the output register holds its word; a pending last
//   character then waits in the input register and o_in_stall rises.
//   Non-last characters keep flowing while the output is stalled.
//   Reset (synchronous, active low) clears config registers, parse state and
//   both valid flags.
module string_to_integer_any_base import stoi_pkg::*; #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // character input
    input  logic                  i_in_valid,
    input  t_in_word              i_in_word,
    output logic                  o_in_stall,
    // result output
    output logic                  o_out_valid,
    output t_out_word             o_out_word,
    input  logic                  i_out_stall,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ALPHA_W-1:0]    i_cfg_data
);

    // parse phases
    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // config registers
    logic [ALPHA_W-1:0] r_alpha_lo;
    logic [ALPHA_W-1:0] r_alpha_hi;
    logic [BLEN_W-1:0]  r_base_len;

    // input register
    logic     r_in_valid;
    t_in_word r_in_word;

    // parse state
    logic [1:0]         r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [VALUE_W-1:0] r_acc, n_acc;

    // output register
    logic      r_out_valid;
    t_out_word r_out_word;

    t_digit             w_digit;
    logic [BLEN_W-1:0]  w_radix;
    logic               w_base_valid;
    logic               w_out_free;
    logic               w_process;
    logic               w_emit;
    logic [VALUE_W-1:0] w_prod;
    logic [VALUE_W-1:0] w_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_lo <= '0;
            r_alpha_hi <= '0;
            r_base_len <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ALPHA_LO: r_alpha_lo <= i_cfg_data;
                CFG_ALPHA_HI: r_alpha_hi <= i_cfg_data;
                CFG_BASE_LEN: r_base_len <= i_cfg_data[BLEN_W-1:0];
                default: ;   // unmapped index
            endcase
        end
    end

    stoi_alphabet #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_alphabet (
        .i_ch         (r_in_word.ch),
        .i_alpha_lo   (r_alpha_lo),
        .i_alpha_hi   (r_alpha_hi),
        .i_base_len   (r_base_len),
        .o_digit      (w_digit),
        .o_radix      (w_radix),
        .o_base_valid (w_base_valid)
    );

    // Flow control: only a last character needs room in the output register.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_process  = r_in_valid && (!r_in_word.last_char || w_out_free);
    assign w_emit     = w_process && r_in_word.last_char;
    assign o_in_stall = r_in_valid && !w_process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    assign w_prod = r_acc * VALUE_W'(w_radix);

    // one parse step for the character in the input register
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (r_phase != PH_STOP) begin
            priority if ((r_phase == PH_SPACE) && is_space(r_in_word.ch)) begin
                n_phase = PH_SPACE;
            end else if ((r_phase != PH_DIGIT) && is_sign(r_in_word.ch)) begin
                n_phase = PH_SIGN;
                n_neg   = r_neg ^ (r_in_word.ch == CH_MINUS);
            end else if (w_digit.hit) begin
                n_phase = PH_DIGIT;
                n_acc   = w_prod + VALUE_W'(w_digit.idx);
            end else begin
                n_phase = PH_STOP;
            end
        end
    end

    assign w_value = n_neg ? (VALUE_W'(0) - n_acc) : n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (w_emit) begin
            // string done: back to reset state
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (w_process) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_word.value      <= w_value;
            r_out_word.base_valid <= w_base_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for string_to_integer_any_base: streams strings one character
// per word, predicts each parsed integer and the alphabet flag, and compares results.
// Depends on stoi_pkg and the string_to_integer_any_base RTL.
module tb import stoi_pkg::*;;

    localparam int RADIX_MAX = 16;      // MAX_DIGITS of the instance
    localparam int SETTLE    = 8;       // quiet cycles before a register write and at the end
    localparam int IDLE_MAX  = 2000;    // cycles without any handshake before giving up
    localparam int RAND_CHARS = 750;    // random character words to send
    localparam int SHOWN_MAX = 10;      // mismatches printed in full

    // index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // parse phases of the predictor
    localparam logic [1:0] P_SPACE = 2'd0;  // skipping leading blanks
    localparam logic [1:0] P_SIGN  = 2'd1;  // inside the sign run
    localparam logic [1:0] P_DIGIT = 2'd2;  // accumulating digits
    localparam logic [1:0] P_STOP  = 2'd3;  // parse ended, ignore the rest of the string

    // ---------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_word   = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ALPHA_W-1:0]   i_cfg_data  = '0;

    string_to_integer_any_base #(
        .MAX_DIGITS (RADIX_MAX)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------------
    // Predictor: shadow copy of the registers and the parse state
    // ---------------------------------------------------------------------
    logic [ALPHA_W-1:0] cfg_alpha_lo  = '0;
    logic [ALPHA_W-1:0] cfg_alpha_hi  = '0;
    logic [BLEN_W-1:0]  cfg_base_len  = '0;
    logic [1:0]         parse_phase   = P_SPACE;
    logic               parse_neg     = 1'b0;
    logic [VALUE_W-1:0] parse_acc     = '0;

    t_out_word parsed_q[$];             // parsed integers still owed by the DUT

    int failures    = 0;
    int chars_sent  = 0;
    int gap_pct     = 0;                // chance of a sender gap before a word
    int stall_pct   = 0;                // chance that a receiver interval is a stall
    int stall_left  = 0;
    int idle_cycles = 0;

    function automatic int pause_len();
        // mostly short pauses, now and then a long one
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        unique case (c)
            CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_sign_char(input logic [CH_W-1:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic [CH_W-1:0] symbol_at(input int i);
        logic [ALPHA_W-1:0] bank;
        bank = (i < 8) ? cfg_alpha_lo : cfg_alpha_hi;
        return bank[(i % 8) * CH_W +: CH_W];
    endfunction

    // lengths above the digit limit are clipped for parsing only
    function automatic int radix_used();
        return (cfg_base_len > RADIX_MAX) ? RADIX_MAX : int'(cfg_base_len);
    endfunction

    // first alphabet position holding c, -1 if none; a zero byte never matches
    function automatic int digit_pos(input logic [CH_W-1:0] c);
        if (c == CH_NUL)
            return -1;
        for (int i = 0; i < radix_used(); i++)
            if (symbol_at(i) == c)
                return i;
        return -1;
    endfunction

    function automatic logic alphabet_is_valid();
        logic [CH_W-1:0] s;
        if (cfg_base_len < MIN_RADIX || cfg_base_len > RADIX_MAX)
            return 1'b0;
        for (int i = 0; i < int'(cfg_base_len); i++) begin
            s = symbol_at(i);
            if (s == CH_NUL || is_sign_char(s) || is_blank(s))
                return 1'b0;
            for (int j = i + 1; j < int'(cfg_base_len); j++)
                if (symbol_at(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
        unique case (idx)
            CFG_ALPHA_LO: cfg_alpha_lo = data;
            CFG_ALPHA_HI: cfg_alpha_hi = data;
            CFG_BASE_LEN: cfg_base_len = data[BLEN_W-1:0];
            default: ;
        endcase
    endtask

    // advance the parse by one accepted character word
    task automatic parse_char(input t_in_word w);
        int        pos;
        t_out_word res;
        pos = digit_pos(w.ch);
        if (parse_phase != P_STOP) begin
            if (parse_phase == P_SPACE && is_blank(w.ch)) begin
                // still in the leading blanks
            end else if (parse_phase != P_DIGIT && is_sign_char(w.ch)) begin
                parse_phase = P_SIGN;
                if (w.ch == CH_MINUS)
                    parse_neg = ~parse_neg;
            end else if (pos >= 0) begin
                parse_phase = P_DIGIT;
                parse_acc = parse_acc * VALUE_W'(radix_used()) + VALUE_W'(pos);
            end else begin
                parse_phase = P_STOP;
            end
        end
        if (w.last_char) begin
            res.value      = parse_neg ? -parse_acc : parse_acc;
            res.base_valid = alphabet_is_valid();
            parsed_q.push_back(res);
            parse_phase = P_SPACE;
            parse_neg   = 1'b0;
            parse_acc   = '0;
        end
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (parsed_q.size() == 0) begin
            failures++;
            if (failures <= SHOWN_MAX)
                $display("unexpected result: value %0d base_valid %0b",
                         got.value, got.base_valid);
        end else begin
            want = parsed_q.pop_front();
            if (got.value !== want.value || got.base_valid !== want.base_valid) begin
                failures++;
                if (failures <= SHOWN_MAX)
                    $display("mismatch: expected value %0d base_valid %0b, got value %0d base_valid %0b",
                             want.value, want.base_valid, got.value, got.base_valid);
            end
        end
    endtask

    // All handshakes are sampled here, at the edge, from pre-edge values.
    // Output is checked before the new input is predicted, so a result can never
    // be matched to an expectation pushed in the same cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                check_result(o_out_word);
            if (i_cfg_valid && o_cfg_ready)
                load_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                parse_char(i_in_word);
        end
    end

    // Receiver: intervals of random length, each stalled with chance stall_pct.
    // With stall_pct at zero the output is never held.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            stall_left  <= pause_len();
        end
    end

    // Watchdog: any accepted word on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_MAX) begin
            $display("timeout: no handshake for %0d cycles", IDLE_MAX);
            $display("string_to_integer_any_base test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Sends one character word. The caller must follow up in the same step with
    // another send or a wait task so valid is lowered or reused exactly once.
    task automatic send_char(input logic [CH_W-1:0] c, input logic last);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat (pause_len()) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= t_in_word'{ch: c, last_char: last};
        do @(posedge i_clk); while (o_in_stall);
        chars_sent++;
    endtask

    // whole text, last word marked
    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == txt.len() - 1);
    endtask

    // sender holds off until every result owed so far has come back
    task automatic wait_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (parsed_q.size() != 0);
    endtask

    // drained and quiet: safe for register writes and for the end of the run
    task automatic wait_idle();
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // length register gets random upper bits; only the low five may matter
    function automatic logic [ALPHA_W-1:0] len_data(input logic [BLEN_W-1:0] len);
        logic [ALPHA_W-1:0] d;
        d = {$urandom, $urandom};
        d[BLEN_W-1:0] = len;
        return d;
    endfunction

    // all three registers, in a rotated order
    task automatic write_alphabet(input logic [ALPHA_W-1:0] lo, input logic [ALPHA_W-1:0] hi,
                                  input logic [BLEN_W-1:0] len);
        logic [CFG_IDX_W-1:0] order [3];
        int                   start;
        order = '{CFG_ALPHA_LO, CFG_ALPHA_HI, CFG_BASE_LEN};
        start = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            unique case (order[(start + k) % 3])
                CFG_ALPHA_LO: write_reg(CFG_ALPHA_LO, lo);
                CFG_ALPHA_HI: write_reg(CFG_ALPHA_HI, hi);
                default:      write_reg(CFG_BASE_LEN, len_data(len));
            endcase
        end
    endtask

    function automatic logic [CH_W-1:0] blank_char();
        unique case ($urandom_range(0, 5))
            0: return CH_TAB;
            1: return CH_LF;
            2: return CH_VT;
            3: return CH_FF;
            4: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] sign_char();
        return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
    endfunction

    // symbol that breaks the validity rules
    function automatic logic [CH_W-1:0] bad_symbol();
        unique case ($urandom_range(0, 2))
            0: return CH_NUL;
            1: return sign_char();
            default: return blank_char();
        endcase
    endfunction

    function automatic logic [CH_W-1:0] digit_char();
        if (radix_used() == 0)
            return CH_W'($urandom_range(0, 255));
        return symbol_at($urandom_range(0, radix_used() - 1));
    endfunction

    function automatic logic [CH_W-1:0] any_char();
        unique case ($urandom_range(0, 5))
            0: return blank_char();
            1: return sign_char();
            2: return digit_char();
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // style 0: every symbol 8'hFF; 1: distinct clean symbols; 2: clean, mostly with faults
    task automatic make_alphabet(input int style, output logic [ALPHA_W-1:0] lo,
                                 output logic [ALPHA_W-1:0] hi);
        logic [CH_W-1:0] sym [16];
        logic [CH_W-1:0] s;
        logic            taken;
        int              fault;
        for (int i = 0; i < 16; i++) begin
            if (style == 0) begin
                sym[i] = 8'hFF;
            end else begin
                do begin
                    s = CH_W'($urandom_range(1, 255));
                    taken = is_blank(s) || is_sign_char(s);
                    for (int j = 0; j < i; j++)
                        if (sym[j] == s)
                            taken = 1'b1;
                end while (taken);
                sym[i] = s;
            end
        end
        if (style == 2) begin
            fault = $urandom_range(0, 3);
            if (fault == 0 || fault == 2)
                sym[$urandom_range(0, 15)] = bad_symbol();
            if (fault == 1 || fault == 2)
                sym[$urandom_range(0, 15)] = sym[$urandom_range(0, 15)];
        end
        for (int i = 0; i < 8; i++) begin
            lo[i * CH_W +: CH_W] = sym[i];
            hi[i * CH_W +: CH_W] = sym[i + 8];
        end
    endtask

    // One string: mostly well formed (blanks, signs, digits, maybe a tail),
    // the rest broken mixes, raw noise, or digits cut by a zero byte.
    task automatic send_random_string();
        logic [CH_W-1:0] txt[$];
        int              kind;
        int              n;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            repeat ($urandom_range(0, 3)) txt.push_back(blank_char());
            repeat ($urandom_range(0, 3)) txt.push_back(sign_char());
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
            repeat (n) txt.push_back(digit_char());
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) txt.push_back(any_char());
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 8)) txt.push_back(any_char());
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 6)) txt.push_back(CH_W'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 3)) txt.push_back(digit_char());
            txt.push_back(CH_NUL);
            repeat ($urandom_range(0, 3)) txt.push_back(digit_char());
        end
        if (txt.size() == 0)
            txt.push_back(digit_char());
        foreach (txt[i])
            send_char(txt[i], i == txt.size() - 1);
        if ($urandom_range(0, 9) == 0)
            wait_results();
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Registers still at reset: radix zero takes no digit, the flag is clear.
    task automatic test_reset_state();
        send_text("-5");
    endtask

    // Decimal alphabet: every blank, a sign run that cancels, a digit, a stop
    // character with a digit after it, the top byte value, and a zero byte.
    task automatic test_decimal();
        wait_idle();
        write_reg(CFG_ALPHA_LO, 64'("76543210"));
        write_reg(CFG_ALPHA_HI, 64'("98"));
        write_reg(CFG_BASE_LEN, len_data(5'd10));
        send_char(CH_TAB, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_VT, 1'b0);
        send_char(CH_FF, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_text("-+-7x9");
        send_char(8'hFF, 1'b1);
        send_char("1", 1'b0);
        send_char(CH_NUL, 1'b1);
        // sender holds until all owed results are back
        wait_results();
    endtask

    // Length beyond the digit limit: parsed as hex, flag clear; nine digits wrap.
    task automatic test_long_radix();
        wait_idle();
        write_reg(CFG_ALPHA_HI, 64'("FEDCBA98"));
        write_reg(CFG_BASE_LEN, len_data(5'd31));
        send_text("FFFFFFFFF");
    endtask

    // Several alphabets, extremes among them, each with its own idling mix.
    task automatic test_random();
        logic [ALPHA_W-1:0] lo;
        logic [ALPHA_W-1:0] hi;
        logic [BLEN_W-1:0]  len;
        int                 style;
        int                 budget;
        for (int ph = 0; ph < 9; ph++) begin
            unique case (ph)
                0: len = 5'd10;
                1: len = MIN_RADIX;
                2: len = 5'd16;
                3: len = 5'd31;
                4: len = 5'd1;
                5: len = 5'd0;
                6: len = 5'd16;
                default: len = BLEN_W'($urandom_range(0, 31));
            endcase
            style = (ph == 6) ? 0 : (ph <= 2) ? 1 : 2;
            make_alphabet(style, lo, hi);
            wait_idle();
            write_alphabet(lo, hi, len);
            if (ph == 7)
                write_reg(CFG_UNUSED, {$urandom, $urandom});
            // first phase runs with no idling at all
            gap_pct   = (ph == 0) ? 0 : $urandom_range(0, 40);
            stall_pct = (ph == 0) ? 0 : $urandom_range(0, 50);
            budget = chars_sent + RAND_CHARS / 9;
            while (chars_sent < budget)
                send_random_string();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_decimal();
        test_long_radix();
        test_random();
        wait_idle();
        if (parsed_q.size() != 0)
            failures++;
        if (failures == 0) begin
            $display("string_to_integer_any_base test passed");
        end else begin
            $display("string_to_integer_any_base test failed");
        end
        $finish;
    end

endmodule

### files.f
sv/stoi_pkg.sv
sv/stoi_alphabet.sv
sv/string_to_integer_any_base.sv
tb/sv/tb.sv
